// ----- rtl/core/rscs_pkg.sv -----
`timescale 1ns / 1ps

package rscs_pkg;

   // Default data memory size in bytes (power of two, 1 KiB .. 1 MiB)
   localparam int unsigned DATA_MEM_BYTES_DEFAULT = 65536;

   // Item kinds
   localparam logic FUNC_EXECUTE = 1'b0;
   localparam logic FUNC_PRELOAD = 1'b1;

   // Opcodes
   localparam logic [5:0] OP_RTYPE = 6'b000000;
   localparam logic [5:0] OP_J     = 6'b000010;
   localparam logic [5:0] OP_BEQ   = 6'b000100;
   localparam logic [5:0] OP_LW    = 6'b100011;
   localparam logic [5:0] OP_SW    = 6'b101011;
   // Upper five opcode bits shared by j and the alternate register format
   localparam logic [4:0] OP_JUMP_PAIR = 5'b00001;

   // ALU operation codes
   localparam logic [2:0] ALU_ADDU = 3'd1;
   localparam logic [2:0] ALU_SUBU = 3'd3;
   localparam logic [2:0] ALU_AND  = 3'd4;
   localparam logic [2:0] ALU_OR   = 3'd5;
   localparam logic [2:0] ALU_NOR  = 3'd7;

   localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        func;
      logic [31:0] instruction;
      logic [15:0] preload_address;
      logic [7:0]  preload_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        halted;
      logic        reg_write_enable;
      logic [4:0]  reg_write_index;
      logic [31:0] reg_write_value;
      logic        mem_write;
      logic [31:0] mem_address;
      logic [31:0] mem_data;
   } rsp_type;

endpackage

// ----- rtl/core/risc_subset_core_step.sv -----
`timescale 1ns / 1ps

// Core for a subset of the MIPS instruction set (addu, subu, and, or,
// nor in register and immediate forms, lw, sw, beq, j, and an all-ones halt word).
// Each request word either executes the instruction fetched at the current
// program counter or preloads one byte of data memory; each produces exactly one
// response word with the next PC, halt status, register write and memory access.
// The block sustains one word per cycle unless rsp_ready stalls the response.
// From acceptance to response each word passes through registers in order:
// an execute register holds the word while
// it is decoded and run through the ALU, and a response register holds the result
// while the load data arrives from data memory. The rate is set by the register
// file and data memory, each read once per word with registered read data;
// dependent instructions run back to back through a bypass from the response
// register and a snoop of register file writes into the held operands. Data
// memory is four byte-wide banks so that an unaligned word is one access; byte
// addresses wrap at DATA_MEM_BYTES, which must be a power of two. Data memory is
// not cleared: read a byte only after it was preloaded or stored. The register
// file reads as zero after reset with no clearing pass.

module risc_subset_core_step
   import rscs_pkg::*;
#(
   parameter int unsigned DATA_MEM_BYTES = DATA_MEM_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int unsigned ADDR_W    = $clog2(DATA_MEM_BYTES);
   localparam int unsigned ROW_W     = ADDR_W - 2;
   localparam int unsigned BANK_ROWS = DATA_MEM_BYTES / 4;

   // ---------------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------------
   logic x_valid_ff, x_valid_in;
   logic y_valid_ff, y_valid_in;
   logic y_free, x_adv, req_fire;

   assign y_free    = !y_valid_ff || rsp_ready;
   assign x_adv     = x_valid_ff && y_free;
   assign req_ready = !x_valid_ff || x_adv;
   assign req_fire  = req_valid && req_ready;

   assign x_valid_in = req_fire || (x_valid_ff && !x_adv);
   assign y_valid_in = x_adv || (y_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
      end else begin
         x_valid_ff <= x_valid_in;
         y_valid_ff <= y_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Architectural state: PC and halt flag, updated as a word leaves execute
   // ---------------------------------------------------------------------
   logic [31:0] pc_ff, pc_in;
   logic        halt_ff, halt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else if (x_adv) begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Execute register
   // ---------------------------------------------------------------------
   req_type x_req_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         x_req_ff <= req_data;
      end
   end

   logic [4:0] req_rs, req_rt, x_rs, x_rt, x_rd;
   assign req_rs = req_data.instruction[25:21];
   assign req_rt = req_data.instruction[20:16];
   assign x_rs   = x_req_ff.instruction[25:21];
   assign x_rt   = x_req_ff.instruction[20:16];
   assign x_rd   = x_req_ff.instruction[15:11];

   // ---------------------------------------------------------------------
   // Register file write, driven from the response register in the first
   // cycle after a word enters it
   // ---------------------------------------------------------------------
   rsp_type     y_rsp_ff;
   logic        y_load_ff;
   logic        y_wr_pend_ff;
   logic [31:0] load_word;
   logic        wr_en;
   logic [4:0]  wr_idx;
   logic [31:0] wr_val;

   assign wr_en  = y_wr_pend_ff && y_rsp_ff.reg_write_enable;
   assign wr_idx = y_rsp_ff.reg_write_index;
   assign wr_val = y_load_ff ? load_word : y_rsp_ff.reg_write_value;

   // ---------------------------------------------------------------------
   // Register file: two registered reads at request acceptance, one write.
   // Entries not yet written read as zero; r0 is never written.
   // ---------------------------------------------------------------------
   logic [31:0] rf_mem_ff [32];
   logic [31:0] rf_vld_ff;
   logic [31:0] rf_a_rd_ff, rf_b_rd_ff;
   logic        rf_a_vld_ff, rf_b_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rf_mem_ff[wr_idx] <= wr_val;
      end
      if (req_fire) begin
         rf_a_rd_ff <= rf_mem_ff[req_rs];
         rf_b_rd_ff <= rf_mem_ff[req_rt];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff <= '0;
      end else if (wr_en) begin
         rf_vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rf_a_vld_ff <= rf_vld_ff[req_rs];
         rf_b_vld_ff <= rf_vld_ff[req_rt];
      end
   end

   // Snoop writes that land after the operands were read
   logic        a_fix_sel_ff, b_fix_sel_ff;
   logic [31:0] a_fix_ff, b_fix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_fix_sel_ff <= 1'b0;
         b_fix_sel_ff <= 1'b0;
      end else if (req_fire) begin
         a_fix_sel_ff <= wr_en && (wr_idx == req_rs);
         b_fix_sel_ff <= wr_en && (wr_idx == req_rt);
      end else begin
         if (wr_en && (wr_idx == x_rs)) begin
            a_fix_sel_ff <= 1'b1;
         end
         if (wr_en && (wr_idx == x_rt)) begin
            b_fix_sel_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         a_fix_ff <= wr_val;
         b_fix_ff <= wr_val;
      end else begin
         if (wr_en && (wr_idx == x_rs)) begin
            a_fix_ff <= wr_val;
         end
         if (wr_en && (wr_idx == x_rt)) begin
            b_fix_ff <= wr_val;
         end
      end
   end

   // Operands: pending write in the response register wins, then the snooped
   // value, then the stored entry
   logic [31:0] a_rf, b_rf, op_a, op_b;

   assign a_rf = a_fix_sel_ff ? a_fix_ff : (rf_a_vld_ff ? rf_a_rd_ff : 32'd0);
   assign b_rf = b_fix_sel_ff ? b_fix_ff : (rf_b_vld_ff ? rf_b_rd_ff : 32'd0);
   assign op_a = (wr_en && (wr_idx == x_rs)) ? wr_val : a_rf;
   assign op_b = (wr_en && (wr_idx == x_rt)) ? wr_val : b_rf;

   // ---------------------------------------------------------------------
   // Decode and execute
   // ---------------------------------------------------------------------
   rsp_type     ex_rsp;
   logic        ex_load, ex_store, ex_preload;
   logic [31:0] ex_addr;

   logic [5:0]  op;
   logic [31:0] instr, imm, pc4, alu_b, alu_res;
   logic [2:0]  alu_code;
   logic        is_load, is_store, is_jump, is_branch, itype, halting;
   logic        wen;
   logic [4:0]  widx;

   always_comb begin
      instr     = x_req_ff.instruction;
      op        = instr[31:26];
      imm       = {{16{instr[15]}}, instr[15:0]};
      pc4       = pc_ff + 32'd4;
      is_load   = (op == OP_LW);
      is_store  = (op == OP_SW);
      is_jump   = (op == OP_J);
      is_branch = (op == OP_BEQ);
      itype     = (op != OP_RTYPE) && (op[5:1] != OP_JUMP_PAIR);
      halting   = halt_ff || (instr == HALT_WORD);

      priority if (is_load || is_store) begin
         alu_code = ALU_ADDU;
      end else if (op == OP_RTYPE) begin
         alu_code = instr[2:0];
      end else begin
         alu_code = op[2:0];
      end

      alu_b = itype ? imm : op_b;
      unique case (alu_code)
         ALU_ADDU: alu_res = op_a + alu_b;
         ALU_SUBU: alu_res = op_a - alu_b;
         ALU_AND:  alu_res = op_a & alu_b;
         ALU_OR:   alu_res = op_a | alu_b;
         ALU_NOR:  alu_res = ~(op_a | alu_b);
         default:  alu_res = 32'd0;
      endcase

      // Destination: immediate forms write rt, register forms write rd
      wen  = 1'b0;
      widx = 5'd0;
      if (!is_jump) begin
         if (itype) begin
            if (!is_store && !is_branch) begin
               wen  = 1'b1;
               widx = x_rt;
            end
         end else begin
            wen  = 1'b1;
            widx = x_rd;
         end
      end
      // Drop writes to r0
      if (widx == 5'd0) begin
         wen = 1'b0;
      end

      ex_rsp     = '0;
      ex_load    = 1'b0;
      ex_store   = 1'b0;
      ex_preload = 1'b0;
      ex_addr    = alu_res;
      pc_in      = pc_ff;
      halt_in    = halt_ff;

      priority if (x_req_ff.func == FUNC_PRELOAD) begin
         ex_preload     = 1'b1;
         ex_rsp.next_pc = pc_ff;
         ex_rsp.halted  = halt_ff;
      end else if (halting) begin
         halt_in        = 1'b1;
         ex_rsp.next_pc = pc_ff;
         ex_rsp.halted  = 1'b1;
      end else begin
         priority if (is_branch && (op_a == op_b)) begin
            pc_in = pc4 + {imm[29:0], 2'b00};
         end else if (is_jump) begin
            pc_in = {pc4[31:28], instr[25:0], 2'b00};
         end else begin
            pc_in = pc4;
         end
         ex_load                 = is_load;
         ex_store                = is_store;
         ex_rsp.next_pc          = pc_in;
         ex_rsp.reg_write_enable = wen;
         ex_rsp.reg_write_index  = wen ? widx : 5'd0;
         // Load value is filled in from memory read data in the response stage
         ex_rsp.reg_write_value  = (wen && !is_load) ? alu_res : 32'd0;
         ex_rsp.mem_write        = is_store;
         ex_rsp.mem_address      = (is_load || is_store) ? alu_res : 32'd0;
         ex_rsp.mem_data         = is_store ? op_b : 32'd0;
      end
   end

   // ---------------------------------------------------------------------
   // Data memory: four byte banks, bank k holds bytes whose address is k mod 4
   // ---------------------------------------------------------------------
   logic [7:0]       dmem_ff    [4][BANK_ROWS];
   logic [7:0]       bank_rd_ff [4];
   logic [ROW_W-1:0] bank_row   [4];
   logic [7:0]       bank_wd    [4];
   logic [3:0]       bank_we;
   logic             bank_re;

   logic [ADDR_W-1:0] acc_addr, pre_addr;
   logic [31:0]       pre_addr32;
   logic [1:0]        lane;
   logic [4:0]        sh;

   always_comb begin
      acc_addr   = ex_addr[ADDR_W-1:0];
      pre_addr32 = {16'd0, x_req_ff.preload_address};
      pre_addr   = pre_addr32[ADDR_W-1:0];
      bank_re    = x_adv && ex_load;
      for (int k = 0; k < 4; k++) begin
         lane = 2'(k) - acc_addr[1:0];
         sh   = {2'd3 - lane, 3'b000};
         if (ex_preload) begin
            bank_row[k] = pre_addr[ADDR_W-1:2];
            bank_wd[k]  = x_req_ff.preload_byte;
            bank_we[k]  = x_adv && (pre_addr[1:0] == 2'(k));
         end else begin
            // Bytes below the start lane wrap into the next row
            bank_row[k] = acc_addr[ADDR_W-1:2] + ROW_W'(2'(k) < acc_addr[1:0]);
            bank_wd[k]  = 8'(op_b >> sh);
            bank_we[k]  = x_adv && ex_store;
         end
      end
   end

   for (genvar k = 0; k < 4; k++) begin : g_bank
      always_ff @(posedge clock) begin
         if (bank_we[k]) begin
            dmem_ff[k][bank_row[k]] <= bank_wd[k];
         end
         if (bank_re) begin
            bank_rd_ff[k] <= dmem_ff[k][bank_row[k]];
         end
      end
   end

   // Reassemble the big-endian word from the banks, starting at the load's lane
   logic [1:0] rd_lane;

   always_comb begin
      load_word = '0;
      for (int i = 0; i < 4; i++) begin
         rd_lane = y_rsp_ff.mem_address[1:0] + 2'(i);
         load_word[31 - 8*i -: 8] = bank_rd_ff[rd_lane];
      end
   end

   // ---------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (x_adv) begin
         y_rsp_ff  <= ex_rsp;
         y_load_ff <= ex_load;
      end
   end

   // Hold the register file write pending for exactly one cycle after entry
   always_ff @(posedge clock) begin
      if (reset) begin
         y_wr_pend_ff <= 1'b0;
      end else begin
         y_wr_pend_ff <= x_adv;
      end
   end

   always_comb begin
      rsp_data = y_rsp_ff;
      if (y_load_ff) begin
         rsp_data.mem_data = load_word;
         if (y_rsp_ff.reg_write_enable) begin
            rsp_data.reg_write_value = load_word;
         end
      end
   end

   assign rsp_valid = y_valid_ff;

endmodule
